>>> src/aes_pkg.sv
// ---------------------------------------------------------------------------
// AES package
// Shared types, constants and byte functions for the AES-128 ECB engine.
// ---------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned CfgIdxW   = 1;
  localparam logic [CfgIdxW-1:0] CfgKeyLow  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgKeyHigh = 1'b1;

  typedef logic [127:0] block_t;

  // Control that travels down the round chain with each beat.
  typedef struct packed {
    logic valid;
    logic decrypt;
  } beat_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Forward SubBytes and ShiftRows; byte r of column c is bit slice 8*(r+4c).
  function automatic block_t sub_shift(input block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(r+4*c) +: 8] = SBOX[s[8*(r+4*((c+r)%4)) +: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic block_t inv_sub_shift(input block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(r+4*((c+r)%4)) +: 8] = INV_SBOX[s[8*(r+4*c) +: 8]];
      end
    end
    inv_sub_shift = t;
  endfunction

  function automatic block_t mix_columns(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[32*c +: 8];
      a1 = s[32*c+8 +: 8];
      a2 = s[32*c+16 +: 8];
      a3 = s[32*c+24 +: 8];
      t[32*c +: 8]    = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[32*c+8 +: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[32*c+16 +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[32*c+24 +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    mix_columns = t;
  endfunction

  // InvMixColumns as a preconditioning step followed by the forward matrix.
  function automatic block_t inv_mix_columns(input block_t s);
    block_t t;
    logic [7:0] u, v;
    for (int c = 0; c < 4; c++) begin
      u = xtime(xtime(s[32*c +: 8] ^ s[32*c+16 +: 8]));
      v = xtime(xtime(s[32*c+8 +: 8] ^ s[32*c+24 +: 8]));
      t[32*c +: 8]    = s[32*c +: 8] ^ u;
      t[32*c+8 +: 8]  = s[32*c+8 +: 8] ^ v;
      t[32*c+16 +: 8] = s[32*c+16 +: 8] ^ u;
      t[32*c+24 +: 8] = s[32*c+24 +: 8] ^ v;
    end
    inv_mix_columns = mix_columns(t);
  endfunction

  // One key schedule step: next round key from the previous one.
  function automatic block_t next_round_key(input block_t k, input logic [7:0] rcon);
    block_t n;
    logic [31:0] t;
    t = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]], SBOX[k[111:104]] ^ rcon};
    n[31:0]   = k[31:0] ^ t;
    n[63:32]  = k[63:32] ^ n[31:0];
    n[95:64]  = k[95:64] ^ n[63:32];
    n[127:96] = k[127:96] ^ n[95:64];
    next_round_key = n;
  endfunction

endpackage

>>> src/aes128_ecb_block_cipher.sv
// ---------------------------------------------------------------------------
// AES-128 ECB block cipher
// Eleven-stage chain of round cells encrypting or decrypting one block a beat.
// ---------------------------------------------------------------------------
//  Channel   Ports                                   Handshake
//  input     in_operation, in_block_low/high          start & !busy
//  result    out_result_low/high                      out_valid, one cycle
//  config    cfg_we, cfg_index, cfg_data              cfg_we
//
// A block is taken every cycle while busy is low; its result is registered
// in the input stage (initial key add) and then once per round cell. busy
// is held high after reset and after a key write (the load_r pulse, then
// the wait_r count down) while the schedule unit steps
// through the ten round keys, one per cycle. The receiver cannot stall.
module aes128_ecb_block_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [63:0] in_block_low,
  input  logic [63:0] in_block_high,
  output logic        out_valid,
  output logic [63:0] out_result_low,
  output logic [63:0] out_result_high,
  input  logic        cfg_we,
  input  logic [aes_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int unsigned NR   = aes_pkg::NumRounds;
  localparam int unsigned CntW = $clog2(NR + 2);

  logic [63:0] key_low_r, key_high_r;
  logic        load_r;
  logic [CntW-1:0] wait_r;
  aes_pkg::block_t rk [NR+1];
  aes_pkg::block_t dk [NR+1];
  aes_pkg::beat_ctl_t ctl [NR+1];
  aes_pkg::block_t st [NR+1];
  aes_pkg::beat_ctl_t ctl0_r;
  aes_pkg::block_t st0_r;
  aes_pkg::block_t blk;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      load_r     <= 1'b0;
      wait_r     <= CntW'(NR + 1);
    end else begin
      load_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          aes_pkg::CfgKeyLow:  key_low_r  <= cfg_data;
          aes_pkg::CfgKeyHigh: key_high_r <= cfg_data;
          default: ;
        endcase
        load_r <= 1'b1;
        wait_r <= CntW'(NR + 1);
      end else if (!load_r && wait_r != '0) begin
        wait_r <= wait_r - 1'b1;
      end
    end
  end

  assign busy = (wait_r != '0) || load_r;

  aes_key_sched u_key_sched (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load_r),
    .key       ({key_high_r, key_low_r}),
    .round_key (rk)
  );

  // Decrypt round i uses key NR-i, with InvMixColumns on the middle keys.
  always_comb begin
    for (int i = 0; i <= NR; i++) begin
      if (i == 0 || i == NR) begin
        dk[i] = rk[NR-i];
      end else begin
        dk[i] = aes_pkg::inv_mix_columns(rk[NR-i]);
      end
    end
  end

  assign accept = start && !busy;
  assign blk    = {in_block_high, in_block_low};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else begin
      ctl0_r.valid   <= accept;
      ctl0_r.decrypt <= in_operation;
    end
    st0_r <= blk ^ (in_operation ? rk[NR] : rk[0]);
  end

  assign ctl[0] = ctl0_r;
  assign st[0]  = st0_r;

  for (genvar g = 1; g <= NR; g++) begin : g_round
    aes_round_cell #(
      .LastRound (g == NR)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl_in    (ctl[g-1]),
      .state_in  (st[g-1]),
      .enc_key   (rk[g]),
      .dec_key   (dk[g]),
      .ctl_out   (ctl[g]),
      .state_out (st[g])
    );
  end

  assign out_valid       = ctl[NR].valid;
  assign out_result_low  = st[NR][63:0];
  assign out_result_high = st[NR][127:64];

endmodule

>>> src/aes_key_sched.sv
// ---------------------------------------------------------------------------
// AES key schedule
// Walks the key through ten schedule steps after reset and after each key
// write and keeps all eleven round keys for the round chain.
// ---------------------------------------------------------------------------
module aes_key_sched (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  aes_pkg::block_t    key,
  output aes_pkg::block_t    round_key [aes_pkg::NumRounds+1]
);

  localparam int unsigned CntW = $clog2(aes_pkg::NumRounds + 1);

  aes_pkg::block_t rk_r [aes_pkg::NumRounds+1];
  aes_pkg::block_t rk_nxt;
  logic [CntW-1:0] step_r;
  logic [7:0]      rcon_r;
  logic            busy_r;

  assign rk_nxt = aes_pkg::next_round_key(rk_r[step_r], rcon_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      step_r <= '0;
      rcon_r <= 8'h01;
      rk_r[0] <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      step_r <= '0;
      rcon_r <= 8'h01;
      rk_r[0] <= key;
    end else if (busy_r) begin
      rk_r[step_r + 1'b1] <= rk_nxt;
      rcon_r <= aes_pkg::xtime(rcon_r);
      step_r <= step_r + 1'b1;
      if (step_r == CntW'(aes_pkg::NumRounds - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign round_key = rk_r;

endmodule

>>> src/aes_round_cell.sv
// ---------------------------------------------------------------------------
// AES round cell
// One registered cipher round, forward or inverse, selected per beat.
// ---------------------------------------------------------------------------
module aes_round_cell #(
  parameter bit LastRound = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  aes_pkg::beat_ctl_t  ctl_in,
  input  aes_pkg::block_t     state_in,
  input  aes_pkg::block_t     enc_key,
  input  aes_pkg::block_t     dec_key,
  output aes_pkg::beat_ctl_t  ctl_out,
  output aes_pkg::block_t     state_out
);

  aes_pkg::block_t state_r, state_nxt;
  aes_pkg::block_t enc_v, dec_v;
  aes_pkg::beat_ctl_t ctl_r;

  // The inverse round runs in equivalent-cipher order, so the decrypt key
  // for middle rounds is already InvMixColumns-transformed.
  always_comb begin
    enc_v = aes_pkg::sub_shift(state_in);
    dec_v = aes_pkg::inv_sub_shift(state_in);
    if (!LastRound) begin
      enc_v = aes_pkg::mix_columns(enc_v);
      dec_v = aes_pkg::inv_mix_columns(dec_v);
    end
    state_nxt = ctl_in.decrypt ? (dec_v ^ dec_key) : (enc_v ^ enc_key);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
    state_r <= state_nxt;
  end

  assign ctl_out   = ctl_r;
  assign state_out = state_r;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AES-128 ECB cipher testbench
// Drives encrypt and decrypt blocks under several keys, predicts each result
// with an independent cipher model and checks every result beat in order.
// ---------------------------------------------------------------------------
module tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned Latency    = 11;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_operation;
  logic [63:0] in_block_low;
  logic [63:0] in_block_high;
  logic        out_valid;
  logic [63:0] out_result_low;
  logic [63:0] out_result_high;
  logic        cfg_we;
  logic [aes_pkg::CfgIdxW-1:0] cfg_index;
  logic [63:0] cfg_data;

  typedef enum logic {OpEncrypt = 1'b0, OpDecrypt = 1'b1} cipher_op_t;

  logic [7:0]   fwd_sbox [256];
  logic [7:0]   rev_sbox [256];
  logic [127:0] key_words;
  logic [127:0] sched [11];
  logic [127:0] pending_blocks [$];
  int unsigned  error_count;
  int unsigned  cycle_count;
  bit           quiet_mode;

  aes128_ecb_block_cipher u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_block_low    (in_block_low),
    .in_block_high   (in_block_high),
    .out_valid       (out_valid),
    .out_result_low  (out_result_low),
    .out_result_high (out_result_high),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] gf_double(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gf_double(a);
    end
    return p;
  endfunction

  // Byte index of the state follows FIPS order: row r of column c is byte r+4c.
  function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic [7:0] m0,
                                            input logic [7:0] m1, input logic [7:0] m2,
                                            input logic [7:0] m3);
    logic [127:0] t;
    logic [7:0] a [4];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) a[r] = s[8*(4*c+r) +: 8];
      for (int r = 0; r < 4; r++) begin
        t[8*(4*c+r) +: 8] = gf_mul(a[r], m0) ^ gf_mul(a[(r+1)%4], m1)
                          ^ gf_mul(a[(r+2)%4], m2) ^ gf_mul(a[(r+3)%4], m3);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] fwd_round_bytes(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[8*(r+4*c) +: 8] = fwd_sbox[s[8*(r+4*((c+r)%4)) +: 8]];
    return t;
  endfunction

  function automatic logic [127:0] rev_round_bytes(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[8*(r+4*((c+r)%4)) +: 8] = rev_sbox[s[8*(r+4*c) +: 8]];
    return t;
  endfunction

  task automatic expand_schedule();
    logic [7:0] w [176];
    logic [7:0] t [4];
    logic [7:0] rcon;
    logic [7:0] t0;
    rcon = 8'h01;
    for (int i = 0; i < 16; i++) w[i] = key_words[8*i +: 8];
    for (int i = 16; i < 176; i += 4) begin
      for (int r = 0; r < 4; r++) t[r] = w[i-4+r];
      if (i % 16 == 0) begin
        t0   = t[0];
        t[0] = fwd_sbox[t[1]] ^ rcon;
        t[1] = fwd_sbox[t[2]];
        t[2] = fwd_sbox[t[3]];
        t[3] = fwd_sbox[t0];
        rcon = gf_double(rcon);
      end
      for (int r = 0; r < 4; r++) w[i+r] = w[i-16+r] ^ t[r];
    end
    for (int k = 0; k < 11; k++)
      for (int i = 0; i < 16; i++) sched[k][8*i +: 8] = w[16*k+i];
  endtask

  function automatic logic [127:0] cipher_block(input cipher_op_t op, input logic [127:0] b);
    logic [127:0] s;
    s = b;
    if (op == OpEncrypt) begin
      s ^= sched[0];
      for (int r = 1; r < 10; r++)
        s = mix_cols(fwd_round_bytes(s), 8'd2, 8'd3, 8'd1, 8'd1) ^ sched[r];
      s = fwd_round_bytes(s) ^ sched[10];
    end else begin
      s ^= sched[10];
      for (int r = 9; r >= 1; r--)
        s = mix_cols(rev_round_bytes(s) ^ sched[r], 8'd14, 8'd11, 8'd13, 8'd9);
      s = rev_round_bytes(s) ^ sched[0];
    end
    return s;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  task automatic idle_cycles(input int unsigned n);
    repeat (n) @(negedge clk);
  endtask

  task automatic send_block(input cipher_op_t op, input logic [63:0] lo, input logic [63:0] hi);
    if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      start = 1'b0;
      idle_cycles($urandom_range(1, 17));
    end
    start         = 1'b1;
    in_operation  = op;
    in_block_low  = lo;
    in_block_high = hi;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_blocks.push_back(cipher_block(op, {hi, lo}));
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_blocks.size() != 0) @(negedge clk);
    idle_cycles(Latency + 2);
  endtask

  task automatic write_key(input logic [aes_pkg::CfgIdxW-1:0] idx, input logic [63:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == aes_pkg::CfgKeyLow) key_words[63:0] = data;
    else key_words[127:64] = data;
    expand_schedule();
  endtask

  task automatic random_word(output logic [63:0] w);
    w = {$urandom(), $urandom()};
  endtask

  // Field extremes under the reset key, the FIPS-197 appendix vector under its key, then random blocks.
  task automatic test_directed();
    logic [63:0] lo, hi;
    send_block(OpEncrypt, 64'h0, 64'h0);
    send_block(OpDecrypt, 64'h0, 64'h0);
    send_block(OpEncrypt, '1, '1);
    send_block(OpDecrypt, '1, '1);
    drain_results();
    write_key(aes_pkg::CfgKeyLow, 64'h0706050403020100);
    write_key(aes_pkg::CfgKeyHigh, 64'h0f0e0d0c0b0a0908);
    send_block(OpEncrypt, 64'h7766554433221100, 64'hffeeddccbbaa9988);
    send_block(OpDecrypt, 64'h30047b6ad8e0c469, 64'h5ac5b47080b7cdd8);
    send_block(OpEncrypt, 64'h0, '1);
    send_block(OpDecrypt, '1, 64'h0);
    send_block(OpEncrypt, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    drain_results();
    write_key(aes_pkg::CfgKeyLow, '1);
    write_key(aes_pkg::CfgKeyHigh, '1);
    for (int i = 0; i < 6; i++) begin
      random_word(lo);
      random_word(hi);
      send_block(cipher_op_t'(i % 2), lo, hi);
    end
    drain_results();
  endtask

  // Random blocks under a fresh key each phase, with a mid-run full drain in phase 1.
  task automatic test_random_keys(input int unsigned phases, input int unsigned per_phase);
    logic [63:0] lo, hi;
    for (int p = 0; p < phases; p++) begin
      random_word(lo);
      if (p == 0) lo = '0;
      write_key(aes_pkg::CfgKeyLow, lo);
      random_word(hi);
      write_key(aes_pkg::CfgKeyHigh, hi);
      for (int i = 0; i < per_phase; i++) begin
        random_word(lo);
        random_word(hi);
        send_block(cipher_op_t'($urandom_range(0, 1)), lo, hi);
        if (i == per_phase / 2 && p == 1) drain_results();
      end
      drain_results();
    end
  endtask

  // Checker: every result beat against the oldest prediction.
  always @(posedge clk) begin
    logic [127:0] want;
    if (rst_n) begin
      cycle_count++;
      if (out_valid) begin
        if (pending_blocks.size() == 0) begin
          report_mismatch("result with no block outstanding");
        end else begin
          want = pending_blocks.pop_front();
          if (out_result_low !== want[63:0])
            report_mismatch($sformatf("low %h want %h", out_result_low, want[63:0]));
          if (out_result_high !== want[127:64])
            report_mismatch($sformatf("high %h want %h", out_result_high, want[127:64]));
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    wait (cycle_count >= CycleLimit);
    $display("FAILURE");
    $finish;
  end

  initial begin
    error_count   = 0;
    quiet_mode    = 1'b0;
    key_words     = '0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_operation  = 1'b0;
    in_block_low  = '0;
    in_block_high = '0;
    cfg_we        = 1'b0;
    cfg_index     = aes_pkg::CfgKeyLow;
    cfg_data      = '0;
    for (int i = 0; i < 256; i++) fwd_sbox[i] = aes_pkg::SBOX[i];
    for (int i = 0; i < 256; i++) rev_sbox[fwd_sbox[i]] = i[7:0];
    expand_schedule();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_keys(4, 100);
    quiet_mode = 1'b1;
    test_random_keys(1, 80);
    if (pending_blocks.size() != 0) report_mismatch("results left outstanding");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
